/* hdl/playfair_encryptor_core_macros.svh */
// Assertion macros for the Playfair encryptor checker.
// Needs nothing else; included by the files that assert.
`ifndef PLAYFAIR_ENCRYPTOR_CORE_MACROS_SVH
`define PLAYFAIR_ENCRYPTOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfe same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfe next-cycle check failed");

`endif

/* hdl/pfe_pkg.sv */
// Shared types, constants and square-geometry helpers for the Playfair encryptor.
// No dependencies; imported by the controller, the datapath and the top level.
package pfe_pkg;

  localparam int SIDE  = 5;
  localparam int CELLS = SIDE * SIDE;
  localparam int ALPHA = 26;

  localparam logic [4:0]       IDX_I      = 5'd8;
  localparam logic [4:0]       IDX_J      = 5'd9;
  localparam logic [4:0]       IDX_X      = 5'd23;
  localparam logic [6:0]       ASCII_A    = 7'h41;
  localparam logic [ALPHA-1:0] USED_RESET = 26'b1 << IDX_J;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_PLAIN  = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic place_key;
    logic fill_start;
    logic fill_step;
    logic set_pending;
    logic load_pair;
    logic sel_b;
    logic cap_pa;
    logic calc;
    logic sel_o2;
    logic out_first;
    logic cap_second;
    logic out_second;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       li_valid;
    logic       pend_valid;
    logic       walk_done;
  } dp_stat_t;

  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    r = '0;
    for (int i = 1; i < SIDE; i++) begin
      if (p >= 5'(i * SIDE)) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p, input logic [2:0] row);
    logic [4:0] base;
    base = 5'(int'(row) * SIDE);
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
    return 5'(int'(row) * SIDE + int'(col));
  endfunction

endpackage

/* hdl/pfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the key square and the letter position table.
module pfe_ram #(
  parameter  int WIDTH = 5,
  parameter  int DEPTH = 25,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pfe_ctrl.sv */
// Sequencing state machine of the Playfair encryptor.
// Depends on pfe_pkg; drives datapath commands and the stream handshakes.
module pfe_ctrl import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_CALC,
    ST_RD_O1,
    ST_RD_O2,
    ST_CAP,
    ST_OUT1,
    ST_OUT2
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (stat.kind)
          KIND_CLEAR:  cmd.clear = 1'b1;
          KIND_KEY:    cmd.place_key = 1'b1;
          KIND_FINISH: begin
            cmd.fill_start = 1'b1;
            state_next     = ST_FILL;
          end
          KIND_PLAIN: begin
            if (stat.li_valid) begin
              if (stat.pend_valid) begin
                cmd.load_pair = 1'b1;
                state_next    = ST_RD_A;
              end else begin
                cmd.set_pending = 1'b1;
              end
            end
          end
          KIND_END: begin
            if (stat.pend_valid) begin
              cmd.load_pair = 1'b1;
              state_next    = ST_RD_A;
            end
          end
          default: ;
        endcase
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.walk_done) state_next = ST_IDLE;
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: begin
        cmd.sel_b  = 1'b1;
        cmd.cap_pa = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_RD_O1;
      end
      ST_RD_O1: state_next = ST_RD_O2;
      ST_RD_O2: begin
        cmd.sel_o2    = 1'b1;
        cmd.out_first = 1'b1;
        state_next    = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_second = 1'b1;
        state_next     = ST_OUT1;
      end
      ST_OUT1: begin
        if (out_ready) begin
          cmd.out_second = 1'b1;
          state_next     = ST_OUT2;
        end
      end
      ST_OUT2: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == ST_IDLE);
      out_valid <= (state_next == ST_OUT1) || (state_next == ST_OUT2);
    end
  end

endmodule

/* hdl/pfe_dp.sv */
// Datapath of the Playfair encryptor: key state, digraph pairing, square lookup.
// Depends on pfe_pkg and pfe_ram; commanded by pfe_ctrl.
module pfe_dp import pfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_letter,
  output logic [6:0] out_letter,
  output logic       out_last
);

  logic [2:0]       kind_r;
  logic [4:0]       li_r;
  logic             li_ok_r;
  logic [ALPHA-1:0] used_mask;
  logic [4:0]       fill_count;
  logic [4:0]       pend;
  logic             pend_valid;
  logic [4:0]       walk;
  logic [4:0]       pair_a;
  logic [4:0]       pair_b;
  logic [4:0]       pa;
  logic [4:0]       o1;
  logic [4:0]       o2;
  logic [6:0]       letter2;

  logic [7:0] up;
  logic [4:0] li;
  logic       li_ok;
  logic [4:0] place_idx;
  logic       place_en;
  logic [4:0] sq_rdata;
  logic [4:0] pos_rdata;
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] o1_next, o2_next;

  always_comb begin
    up = in_letter;
    if (in_letter inside {[8'h61:8'h7A]}) up = in_letter - 8'h20;
    li_ok = up inside {[8'h41:8'h5A]};
    li    = 5'(up - 8'h41);
    if (li == IDX_J) li = IDX_I;
  end

  assign place_idx = cmd.fill_step ? walk : li_r;
  assign place_en  = ((cmd.place_key && li_ok_r) || cmd.fill_step)
                     && !used_mask[place_idx] && (fill_count < 5'(CELLS));

  pfe_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square (
    .clk   (clk),
    .we    (place_en),
    .waddr (fill_count),
    .wdata (place_idx),
    .raddr (cmd.sel_o2 ? o2 : o1),
    .rdata (sq_rdata)
  );

  pfe_ram #(.WIDTH(5), .DEPTH(ALPHA)) u_position (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_idx),
    .wdata (fill_count),
    .raddr (cmd.sel_b ? pair_b : pair_a),
    .rdata (pos_rdata)
  );

  always_comb begin
    r1 = cell_row(pa);
    c1 = cell_col(pa, r1);
    r2 = cell_row(pos_rdata);
    c2 = cell_col(pos_rdata, r2);
    if (r1 == r2) begin
      o1_next = cell_of(r1, wrap_inc(c1));
      o2_next = cell_of(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      o1_next = cell_of(wrap_inc(r1), c1);
      o2_next = cell_of(wrap_inc(r2), c2);
    end else begin
      o1_next = cell_of(r1, c2);
      o2_next = cell_of(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_mask  <= USED_RESET;
      fill_count <= '0;
      pend       <= '0;
      pend_valid <= 1'b0;
      walk       <= '0;
    end else begin
      if (cmd.clear) begin
        used_mask  <= USED_RESET;
        fill_count <= '0;
        pend       <= '0;
        pend_valid <= 1'b0;
      end else if (place_en) begin
        used_mask[place_idx] <= 1'b1;
        fill_count           <= fill_count + 5'd1;
      end
      if (cmd.fill_start) begin
        walk <= '0;
      end else if (cmd.fill_step) begin
        walk <= walk + 5'd1;
      end
      if (cmd.set_pending) begin
        pend       <= li_r;
        pend_valid <= 1'b1;
      end else if (cmd.load_pair) begin
        if (!(kind_r == KIND_PLAIN && li_r == pend)) begin
          pend       <= '0;
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      li_r    <= li;
      li_ok_r <= li_ok;
    end
    if (cmd.load_pair) begin
      pair_a <= pend;
      pair_b <= (kind_r == KIND_END || li_r == pend) ? IDX_X : li_r;
    end
    if (cmd.cap_pa) pa <= pos_rdata;
    if (cmd.calc) begin
      o1 <= o1_next;
      o2 <= o2_next;
    end
    if (cmd.out_first) begin
      out_letter <= ASCII_A + {2'b00, sq_rdata};
      out_last   <= 1'b0;
    end else if (cmd.out_second) begin
      out_letter <= letter2;
      out_last   <= 1'b1;
    end
    if (cmd.cap_second) letter2 <= ASCII_A + {2'b00, sq_rdata};
  end

  assign stat.kind       = kind_r;
  assign stat.li_valid   = li_ok_r;
  assign stat.pend_valid = pend_valid;
  assign stat.walk_done  = (walk == 5'(ALPHA - 1));

endmodule

/* hdl/playfair_encryptor_core.sv */
// Key, clear and plaintext items that give no result go through decode back to idle;
// finishing the square walks the alphabet after decode, one alphabet letter per cycle.
// A digraph reads the two letter positions, computes and reads the cipher cells, then offers
// its first cipher letter and its second right after that letter's transfer, taking no
// input meanwhile; position table and square each have one read port, read in turn.
// Reset (rst, synchronous): clears key mask, fill count, walk and pending letter; not the tables.
module playfair_encryptor_core import pfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] letter
  input  logic [2:0] s_axis_tuser,  // [2:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] cipher_letter, [7] zero
  output logic       m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [6:0] cipher_letter;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pfe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_axis_tuser),
    .in_letter  (s_axis_tdata),
    .out_letter (cipher_letter),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, cipher_letter};

endmodule

/* hdl/pfe_checker.sv */
// Port-level checks of the Playfair encryptor, bound to the top level.
// Depends on playfair_encryptor_core_macros.svh.
`include "playfair_encryptor_core_macros.svh"

module pfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  `PFE_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `PFE_ASSERT_SAME(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)
  `PFE_ASSERT_NEXT(a_pair_second, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast)
  `PFE_ASSERT_NEXT(a_ready_after, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)

endmodule

bind playfair_encryptor_core pfe_checker u_pfe_checker (.*);
